// ===== hdl/spfe_pkg.sv =====
// ----------------------------------------------------------------------------
// spfe_pkg - shared types and constants
// Widths, codes, and controller/datapath interface structs for the
// segment/polygon first-entry unit.
// ----------------------------------------------------------------------------
package spfe_pkg;

  // field widths
  localparam int VertexCountW = 5;
  localparam int SlotW        = 4;
  localparam int CoordW       = 32;
  localparam int EdgeW        = 4;
  localparam int DiffW        = CoordW + 1;      // coordinate differences
  localparam int NumW         = 68;              // cross products, signed
  localparam int ProdW        = 2 * NumW;        // multiplier result
  localparam int QuotW        = DiffW + 1;       // entry offset magnitude
  localparam int DigitW       = 8;               // multiplier digit per cycle

  // stream payload widths
  localparam int SDataW = 136;
  localparam int MDataW = 72;

  // configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic CfgVertexCountIdx = 1'b0;
  localparam logic [VertexCountW-1:0] VertexCountReset = 5'd3;

  // parameter defaults
  localparam int DefMaxVertices   = 16;
  localparam int DefCoordFracBits = 16;
  localparam int DefTTolLsb       = 0;

  localparam int MinVertices = 3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // operand pair for the shared multiplier
  typedef enum logic [3:0] {
    MS_DX_EY,
    MS_DY_EX,
    MS_FX_EY,
    MS_FY_EX,
    MS_FX_DY,
    MS_FY_DX,
    MS_NUM_BDEN,
    MS_BNUM_DN,
    MS_BNUM_DX,
    MS_BNUM_DY
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_LD0,
    ST_RDB,
    ST_LDB,
    ST_MSTART,
    ST_MWAIT,
    ST_NORM,
    ST_WIN,
    ST_CHK,
    ST_DECIDE,
    ST_NEXT,
    ST_FIN,
    ST_DIVLD,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     vtx_wr;
    logic     query_ld;
    logic     rd_zero;
    logic     ld_first;
    logic     ld_b;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_wr;
    logic     norm;
    logic     win;
    logic     take;
    logic     next;
    logic     div_ld;
    logic     div_step;
    logic     sum_ld;
    logic     axis;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic mul_done;
    logic den_zero;
    logic pass;
    logic have;
    logic lt;
    logic last_edge;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [NumW-1:0] ext_num(input logic [DiffW-1:0] v);
    ext_num = {{(NumW-DiffW){v[DiffW-1]}}, v};
  endfunction

endpackage

// ===== hdl/spfe_ram.sv =====
// ----------------------------------------------------------------------------
// spfe_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spfe_ram #(
  parameter int DataW = 64,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/spfe_mul.sv =====
// ----------------------------------------------------------------------------
// spfe_mul - sequential signed multiplier
// Sign-magnitude shift-add, one DigitW-bit digit of b per cycle; stops as
// soon as the remaining digits of b are zero.
// ----------------------------------------------------------------------------
module spfe_mul #(
  parameter int W  = 68,
  parameter int DW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] res_o
);

  logic           busy_q, done_q, neg_q;
  logic [2*W-1:0] a_q, acc_q;
  logic [W-1:0]   b_q;
  logic [W-1:0]   a_mag, b_mag, b_nxt;
  logic [2*W+DW-1:0] pp;

  assign a_mag = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + W'(1)) : b_i;
  assign pp    = a_q * b_q[DW-1:0];
  assign b_nxt = b_q >> DW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= (b_nxt != '0);
      done_q <= (b_nxt == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{W{1'b0}}, a_mag};
      b_q   <= b_mag;
      acc_q <= '0;
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      acc_q <= acc_q + pp[2*W-1:0];
      a_q   <= a_q << DW;
      b_q   <= b_nxt;
    end
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? (~acc_q + (2*W)'(1)) : acc_q;

endmodule

// ===== hdl/spfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// spfe_ctrl - query sequencer
// Walks the edges, orders the multiplier jobs, the compare and the divide.
// ----------------------------------------------------------------------------
module spfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  spfe_pkg::op_e     in_op_i,
  input  spfe_pkg::dp_stat_t stat_i,
  output logic              in_ready_o,
  output spfe_pkg::dp_cmd_t cmd_o
);
  import spfe_pkg::*;

  ctrl_state_e state_q, state_d;
  mul_sel_e    sel_q, sel_d;
  logic        axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= MS_DX_EY;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      axis_q  <= axis_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_op_i == OP_QUERY) state_d = ST_RD0;
      end
      ST_RD0:  state_d = stat_i.n_small ? ST_OUT : ST_LD0;
      ST_LD0:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_LDB;
      ST_LDB: begin
        sel_d   = MS_DX_EY;
        state_d = ST_MSTART;
      end
      ST_MSTART: state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (stat_i.mul_done) begin
          state_d = ST_MSTART;
          case (sel_q)
            MS_DX_EY:    sel_d = MS_DY_EX;
            MS_DY_EX:    sel_d = MS_FX_EY;
            MS_FX_EY:    sel_d = MS_FY_EX;
            MS_FY_EX:    sel_d = MS_FX_DY;
            MS_FX_DY:    sel_d = MS_FY_DX;
            MS_FY_DX:    state_d = ST_NORM;
            MS_NUM_BDEN: sel_d = MS_BNUM_DN;
            MS_BNUM_DN:  state_d = ST_DECIDE;
            MS_BNUM_DX:  state_d = ST_DIVLD;
            MS_BNUM_DY:  state_d = ST_DIVLD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_NORM: state_d = stat_i.den_zero ? ST_NEXT : ST_WIN;
      ST_WIN:  state_d = ST_CHK;
      ST_CHK: begin
        if (!stat_i.pass || !stat_i.have) begin
          state_d = ST_NEXT;
        end else begin
          sel_d   = MS_NUM_BDEN;
          state_d = ST_MSTART;
        end
      end
      ST_DECIDE: state_d = ST_NEXT;
      ST_NEXT:   state_d = stat_i.last_edge ? ST_FIN : ST_RDB;
      ST_FIN: begin
        if (stat_i.have) begin
          sel_d   = MS_BNUM_DX;
          axis_d  = 1'b0;
          state_d = ST_MSTART;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIVLD: state_d = ST_DIV;
      ST_DIV: begin
        if (stat_i.div_last) begin
          if (!axis_q) begin
            axis_d  = 1'b1;
            sel_d   = MS_BNUM_DY;
            state_d = ST_MSTART;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT:  state_d = stat_i.out_busy ? ST_OUT : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = sel_q;
    cmd_o.axis    = axis_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.vtx_wr   = in_valid_i && in_op_i == OP_WRITE;
        cmd_o.query_ld = in_valid_i && in_op_i == OP_QUERY;
      end
      ST_RD0:    cmd_o.rd_zero   = 1'b1;
      ST_LD0:    cmd_o.ld_first  = 1'b1;
      ST_RDB:    cmd_o.rd_zero   = 1'b0;
      ST_LDB:    cmd_o.ld_b      = 1'b1;
      ST_MSTART: cmd_o.mul_start = 1'b1;
      ST_MWAIT:  cmd_o.mul_wr    = stat_i.mul_done;
      ST_NORM:   cmd_o.norm      = 1'b1;
      ST_WIN:    cmd_o.win       = 1'b1;
      ST_CHK:    cmd_o.take      = stat_i.pass && !stat_i.have;
      ST_DECIDE: cmd_o.take      = stat_i.lt;
      ST_NEXT:   cmd_o.next      = 1'b1;
      ST_FIN:    cmd_o.next      = 1'b0;
      ST_DIVLD:  cmd_o.div_ld    = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.sum_ld   = stat_i.div_last;
      end
      ST_OUT:    cmd_o.out_ld    = !stat_i.out_busy;
      default:   cmd_o.next      = 1'b0;
    endcase
  end

endmodule

// ===== hdl/spfe_dpath.sv =====
// ----------------------------------------------------------------------------
// spfe_dpath - vertex store and arithmetic
// Vertex RAM, shared multiplier, window tests, best-edge registers,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module spfe_dpath #(
  parameter int MaxVertices   = spfe_pkg::DefMaxVertices,
  parameter int CoordFracBits = spfe_pkg::DefCoordFracBits,
  parameter int TTolLsb       = spfe_pkg::DefTTolLsb
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spfe_pkg::dp_cmd_t                    cmd_i,
  output spfe_pkg::dp_stat_t                   stat_o,
  input  logic [spfe_pkg::VertexCountW-1:0]    vcount_i,
  input  logic [spfe_pkg::SlotW-1:0]           slot_i,
  input  logic [spfe_pkg::CoordW-1:0]          first_x_i,
  input  logic [spfe_pkg::CoordW-1:0]          first_y_i,
  input  logic [spfe_pkg::CoordW-1:0]          second_x_i,
  input  logic [spfe_pkg::CoordW-1:0]          second_y_i,
  input  logic                                 m_ready_i,
  output logic                                 out_valid_o,
  output logic                                 out_found_o,
  output logic [spfe_pkg::EdgeW-1:0]           out_edge_o,
  output logic [spfe_pkg::CoordW-1:0]          out_x_o,
  output logic [spfe_pkg::CoordW-1:0]          out_y_o
);
  import spfe_pkg::*;

  localparam int AW    = $clog2(MaxVertices);
  localparam int CntW  = VertexCountW;
  localparam int WW    = NumW + CoordFracBits + 2;
  localparam int RW    = NumW + QuotW;
  localparam int DcntW = $clog2(QuotW);
  localparam int SumW  = QuotW + 2;
  localparam logic signed [WW-1:0]   TolW  = WW'(TTolLsb);
  localparam logic signed [SumW-1:0] SatHi = SumW'(33'sh0_7FFF_FFFF);
  localparam logic signed [SumW-1:0] SatLo = -SatHi - SumW'(1);

  // query operands
  logic [CoordW-1:0] p0x_q, p0y_q;
  logic [DiffW-1:0]  dx_q, dy_q;
  logic [CntW-1:0]   n_q, i_q, i_p1, j;
  // edge end points and differences
  logic [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [DiffW-1:0]  ex_q, ey_q, fx_q, fy_q;
  // cross products
  logic [ProdW-1:0]  acc_q, prod_q;
  logic [NumW-1:0]   den_q, tn_q, sn_q, num_q, dn_q;
  logic              pass_q, lt_q, have_q;
  logic [NumW-1:0]   best_num_q, best_den_q;
  logic [CntW-1:0]   best_edge_q;
  // divider
  logic [RW-1:0]     rem_q, dv_q;
  logic [QuotW-1:0]  quo_q, quo_nxt;
  logic              q_bit;
  logic              dneg_q;
  logic [DcntW-1:0]  dcnt_q;
  logic [CoordW-1:0] resx_q, resy_q;
  // output register
  logic              out_valid_q, out_found_q;
  logic [EdgeW-1:0]  out_edge_q;
  logic [CoordW-1:0] out_x_q, out_y_q;

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [2*CoordW-1:0] ram_rdata;
  logic [CoordW-1:0] rd_x, rd_y;

  // multiplier
  logic [NumW-1:0]   mul_a, mul_b;
  logic [ProdW-1:0]  mul_res;
  logic              mul_done;

  logic              tn_neg, tn_gt, win_ok;
  logic [ProdW-1:0]  prod_mag;
  logic [QuotW:0]    quo_ext, qs;
  logic [SumW-1:0]   sum, p0_ext;
  logic [CoordW-1:0] sat;

  function automatic logic in_win(input logic [NumW-1:0] num,
                                  input logic [NumW-1:0] den);
    logic signed [WW-1:0] num_w, den_w, scaled, lo, hi;
    num_w  = $signed({{(WW-NumW){num[NumW-1]}}, num});
    den_w  = $signed({{(WW-NumW){den[NumW-1]}}, den});
    scaled = num_w <<< CoordFracBits;
    lo     = scaled + den_w * TolW;
    hi     = (den_w <<< CoordFracBits) + den_w * TolW;
    in_win = !lo[WW-1] && (scaled <= hi);
  endfunction

  assign i_p1 = i_q + CntW'(1);
  assign j    = (i_p1 == n_q) ? '0 : i_p1;

  assign ram_we    = cmd_i.vtx_wr && (32'(slot_i) < 32'(MaxVertices));
  assign ram_raddr = cmd_i.rd_zero ? '0 : AW'(j);
  assign rd_x      = ram_rdata[CoordW-1:0];
  assign rd_y      = ram_rdata[2*CoordW-1:CoordW];

  spfe_ram #(
    .DataW(2 * CoordW),
    .Depth(MaxVertices)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(slot_i)),
    .wdata_i({first_y_i, first_x_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case (cmd_i.mul_sel)
      MS_DX_EY:    begin mul_a = ext_num(dx_q); mul_b = ext_num(ey_q); end
      MS_DY_EX:    begin mul_a = ext_num(dy_q); mul_b = ext_num(ex_q); end
      MS_FX_EY:    begin mul_a = ext_num(fx_q); mul_b = ext_num(ey_q); end
      MS_FY_EX:    begin mul_a = ext_num(fy_q); mul_b = ext_num(ex_q); end
      MS_FX_DY:    begin mul_a = ext_num(fx_q); mul_b = ext_num(dy_q); end
      MS_FY_DX:    begin mul_a = ext_num(fy_q); mul_b = ext_num(dx_q); end
      MS_NUM_BDEN: begin mul_a = num_q;         mul_b = best_den_q;    end
      MS_BNUM_DN:  begin mul_a = best_num_q;    mul_b = dn_q;          end
      MS_BNUM_DX:  begin mul_a = best_num_q;    mul_b = ext_num(dx_q); end
      MS_BNUM_DY:  begin mul_a = best_num_q;    mul_b = ext_num(dy_q); end
      default:     begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  spfe_mul #(
    .W (NumW),
    .DW(DigitW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign tn_neg = tn_q[NumW-1];
  assign tn_gt  = $signed(tn_q) > $signed(den_q);
  assign win_ok = in_win(tn_q, den_q) && in_win(sn_q, den_q);

  assign prod_mag = prod_q[ProdW-1] ? (~prod_q + ProdW'(1)) : prod_q;

  // one restoring step: quotient bit and the shifted quotient
  assign q_bit   = rem_q >= dv_q;
  assign quo_nxt = {quo_q[QuotW-2:0], q_bit};

  // entry coordinate: p0 + signed quotient, clipped to 32 bits
  // sum_ld fires with the last divide step, so the sum takes that step's bit
  assign quo_ext = {1'b0, quo_nxt};
  assign qs      = dneg_q ? (~quo_ext + (QuotW+1)'(1)) : quo_ext;
  assign p0_ext  = cmd_i.axis ? {{(SumW-CoordW){p0y_q[CoordW-1]}}, p0y_q}
                              : {{(SumW-CoordW){p0x_q[CoordW-1]}}, p0x_q};
  assign sum     = p0_ext + {qs[QuotW], qs};
  always_comb begin
    if ($signed(sum) > SatHi)      sat = SatHi[CoordW-1:0];
    else if ($signed(sum) < SatLo) sat = SatLo[CoordW-1:0];
    else                           sat = sum[CoordW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.query_ld)  have_q <= 1'b0;
      else if (cmd_i.take) have_q <= 1'b1;
      if (cmd_i.out_ld)    out_valid_q <= 1'b1;
      else if (m_ready_i)  out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_ld) begin
      p0x_q <= first_x_i;
      p0y_q <= first_y_i;
      dx_q  <= {second_x_i[CoordW-1], second_x_i} - {first_x_i[CoordW-1], first_x_i};
      dy_q  <= {second_y_i[CoordW-1], second_y_i} - {first_y_i[CoordW-1], first_y_i};
      n_q   <= (32'(vcount_i) > 32'(MaxVertices)) ? CntW'(MaxVertices) : vcount_i;
    end
    if (cmd_i.ld_first) begin
      ax_q <= rd_x;
      ay_q <= rd_y;
      i_q  <= '0;
    end
    if (cmd_i.ld_b) begin
      bx_q <= rd_x;
      by_q <= rd_y;
      ex_q <= {rd_x[CoordW-1], rd_x} - {ax_q[CoordW-1], ax_q};
      ey_q <= {rd_y[CoordW-1], rd_y} - {ay_q[CoordW-1], ay_q};
      fx_q <= {ax_q[CoordW-1], ax_q} - {p0x_q[CoordW-1], p0x_q};
      fy_q <= {ay_q[CoordW-1], ay_q} - {p0y_q[CoordW-1], p0y_q};
    end
    if (cmd_i.next) begin
      i_q  <= i_p1;
      ax_q <= bx_q;
      ay_q <= by_q;
    end
    if (cmd_i.mul_wr) begin
      case (cmd_i.mul_sel)
        MS_DX_EY, MS_FX_EY, MS_FX_DY, MS_NUM_BDEN: acc_q <= mul_res;
        MS_DY_EX:   den_q  <= NumW'(acc_q - mul_res);
        MS_FY_EX:   tn_q   <= NumW'(acc_q - mul_res);
        MS_FY_DX:   sn_q   <= NumW'(acc_q - mul_res);
        MS_BNUM_DN: lt_q   <= $signed(acc_q) < $signed(mul_res);
        MS_BNUM_DX, MS_BNUM_DY: prod_q <= mul_res;
        default:    acc_q  <= acc_q;
      endcase
    end
    if (cmd_i.norm && den_q[NumW-1]) begin
      den_q <= ~den_q + NumW'(1);
      tn_q  <= ~tn_q + NumW'(1);
      sn_q  <= ~sn_q + NumW'(1);
    end
    if (cmd_i.win) begin
      pass_q <= win_ok;
      if (tn_neg) begin
        num_q <= '0;
        dn_q  <= NumW'(1);
      end else if (tn_gt) begin
        num_q <= NumW'(1);
        dn_q  <= NumW'(1);
      end else begin
        num_q <= tn_q;
        dn_q  <= den_q;
      end
    end
    if (cmd_i.take) begin
      best_num_q  <= num_q;
      best_den_q  <= dn_q;
      best_edge_q <= i_q;
    end
    if (cmd_i.div_ld) begin
      dneg_q <= prod_q[ProdW-1];
      rem_q  <= RW'(prod_mag);
      dv_q   <= RW'(best_den_q) << (QuotW - 1);
      quo_q  <= '0;
      dcnt_q <= DcntW'(QuotW - 1);
    end else if (cmd_i.div_step) begin
      if (q_bit) begin
        rem_q <= rem_q - dv_q;
      end
      quo_q  <= quo_nxt;
      dv_q   <= dv_q >> 1;
      dcnt_q <= dcnt_q - DcntW'(1);
    end
    if (cmd_i.sum_ld) begin
      if (cmd_i.axis) resy_q <= sat;
      else            resx_q <= sat;
    end
    if (cmd_i.out_ld) begin
      out_found_q <= have_q;
      out_edge_q  <= have_q ? EdgeW'(best_edge_q) : '0;
      out_x_q     <= have_q ? resx_q : '0;
      out_y_q     <= have_q ? resy_q : '0;
    end
  end

  assign stat_o.n_small   = n_q < CntW'(MinVertices);
  assign stat_o.mul_done  = mul_done;
  assign stat_o.den_zero  = den_q == '0;
  assign stat_o.pass      = pass_q;
  assign stat_o.have      = have_q;
  assign stat_o.lt        = lt_q;
  assign stat_o.last_edge = i_p1 == n_q;
  assign stat_o.div_last  = dcnt_q == '0;
  assign stat_o.out_busy  = out_valid_q && !m_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_edge_o  = out_edge_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;

endmodule

// ===== hdl/segment_polygon_first_entry_unit.sv =====
// ----------------------------------------------------------------------------
// segment_polygon_first_entry_unit - first polygon edge crossed by a segment
// Holds up to MaxVertices polygon vertices (Q16.16) written by write items.
// A query item gives a segment P0->P1; the unit walks edges i -> i+1 (last
// edge wraps to vertex 0), solves each crossing exactly with wide integer
// cross products, skips parallel edges, keeps the smallest parameter t
// (clamped to 0..1, lowest edge wins a tie) and returns found, the edge and
// the entry point P0 + t*(P1-P0). A write item returns nothing. A query
// first reads vertex 0, then per edge reads the next vertex from the RAM
// and runs six products on the shared 8-bit-digit multiplier, which stops
// early on small operands, plus two more products on edges that must be
// compared against the current best; the entry point adds two products and
// two 34-step restoring divides. The vertex RAM is not cleared: a query
// touching a never-written vertex gives undefined output. With fewer than
// three vertices a query returns found = 0. The vertex count register sits
// at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module segment_polygon_first_entry_unit #(
  parameter int MaxVertices   = spfe_pkg::DefMaxVertices,
  parameter int CoordFracBits = spfe_pkg::DefCoordFracBits,
  parameter int TTolLsb       = spfe_pkg::DefTTolLsb
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // vertex_slot[3:0], first_x[35:4], first_y[67:36], second_x[99:68],
  // second_y[131:100], zero pad[135:132]
  input  logic [spfe_pkg::SDataW-1:0]  s_tdata,
  // op[0]
  input  logic                         s_tuser,
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // edge_index[3:0], entry_x[35:4], entry_y[67:36], zero pad[71:68]
  output logic [spfe_pkg::MDataW-1:0]  m_tdata,
  // found[0]
  output logic                         m_tuser,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spfe_pkg::PaddrW-1:0]  paddr,
  input  logic [spfe_pkg::PdataW-1:0]  pwdata,
  output logic [spfe_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import spfe_pkg::*;

  logic [VertexCountW-1:0] vcount_q;
  logic                    cfg_wr;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic              out_found;
  logic [EdgeW-1:0]  out_edge;
  logic [CoordW-1:0] out_x, out_y;

  // register file: one word, the vertex count
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CfgVertexCountIdx);
  assign prdata = (paddr[2] == CfgVertexCountIdx) ? PdataW'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountReset;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[VertexCountW-1:0];
    end
  end

  spfe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_tvalid),
    .in_op_i   (op_e'(s_tuser)),
    .stat_i    (stat),
    .in_ready_o(s_tready),
    .cmd_o     (cmd)
  );

  spfe_dpath #(
    .MaxVertices  (MaxVertices),
    .CoordFracBits(CoordFracBits),
    .TTolLsb      (TTolLsb)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .vcount_i   (vcount_q),
    .slot_i     (s_tdata[3:0]),
    .first_x_i  (s_tdata[35:4]),
    .first_y_i  (s_tdata[67:36]),
    .second_x_i (s_tdata[99:68]),
    .second_y_i (s_tdata[131:100]),
    .m_ready_i  (m_tready),
    .out_valid_o(m_tvalid),
    .out_found_o(out_found),
    .out_edge_o (out_edge),
    .out_x_o    (out_x),
    .out_y_o    (out_y)
  );

  assign m_tdata = {4'b0000, out_y, out_x, out_edge};
  assign m_tuser = out_found;

  // a query occupies the unit: no item taken the cycle after
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
    else $error("item accepted right after a query");

  // result register never overwritten while a result is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> !(m_tvalid && !m_tready))
    else $error("result overwritten before it was taken");

  // a miss reports all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero payload");

  // multiplier is never restarted mid-job
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |=> !cmd.mul_start && !stat.mul_done)
    else $error("multiplier start sequencing broken");

endmodule

// ===== tb/tb_segment_polygon_first_entry_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_polygon_first_entry_unit - self-checking bench for the unit
// Drives vertex writes and segment queries over the stream port with random
// gaps and back-pressure, and reprograms the vertex count over APB between
// phases. An exact wide-integer predictor computes the expected crossing for
// every accepted query, and each result item is checked field by field.
// ----------------------------------------------------------------------------
module tb_segment_polygon_first_entry_unit;
  import spfe_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct {
    logic             found;
    logic [EdgeW-1:0] edge_num;
    coord_t           ent_x;
    coord_t           ent_y;
  } crossing_t;

  // Tracks the vertex table and the vertex count, and predicts the first edge
  // crossed by each accepted query.
  class crossing_scoreboard;
    coord_t           vtx_x[DefMaxVertices];
    coord_t           vtx_y[DefMaxVertices];
    int unsigned      n_vertices = VertexCountReset;
    crossing_t        pending_q[$];
    int unsigned      errors = 0;

    // Exact test of num/den in [-tol, 1+tol], den > 0.
    function automatic bit in_window(wide_t num, wide_t den);
      wide_t scaled, lo, hi;
      scaled = num * (wide_t'(1) <<< DefCoordFracBits);
      lo     = scaled + wide_t'(DefTTolLsb) * den;
      hi     = ((wide_t'(1) <<< DefCoordFracBits) + wide_t'(DefTTolLsb)) * den;
      return (lo >= 0) && (scaled <= hi);
    endfunction

    // P0 + trunc(num*(p1-p0)/den), saturated.
    function automatic coord_t entry_coord(coord_t p0, coord_t p1,
                                           wide_t num, wide_t den);
      wide_t r;
      r = wide_t'(p0) + (num * (wide_t'(p1) - wide_t'(p0))) / den;
      if (r < wide_t'(-64'sd2147483648)) return 32'sh8000_0000;
      if (r > wide_t'(64'sd2147483647))  return 32'sh7fff_ffff;
      return r[CoordW-1:0];
    endfunction

    function void note_item(op_e op, logic [SlotW-1:0] slot,
                            coord_t x0, coord_t y0, coord_t x1, coord_t y1);
      crossing_t   res;
      int unsigned n, j;
      wide_t       ax, ay, ex, ey, dx, dy, fx, fy, den, tn, sn, num, dn;
      wide_t       best_num, best_den;
      bit          have;
      if (op == OP_WRITE) begin
        if (slot < DefMaxVertices) begin
          vtx_x[slot] = x0;
          vtx_y[slot] = y0;
        end
        return;
      end
      res = '{1'b0, '0, '0, '0};
      have = 0; best_num = 0; best_den = 1;
      n = (n_vertices > DefMaxVertices) ? DefMaxVertices : n_vertices;
      if (n >= MinVertices) begin
        for (int unsigned i = 0; i < n; i++) begin
          j  = (i + 1 == n) ? 0 : i + 1;
          ax = vtx_x[i];
          ay = vtx_y[i];
          ex = wide_t'(vtx_x[j]) - ax;
          ey = wide_t'(vtx_y[j]) - ay;
          dx = wide_t'(x1) - wide_t'(x0);
          dy = wide_t'(y1) - wide_t'(y0);
          fx = ax - wide_t'(x0);
          fy = ay - wide_t'(y0);
          den = dx * ey - dy * ex;
          if (den == 0) continue;       // parallel edge
          tn = fx * ey - fy * ex;
          sn = fx * dy - fy * dx;
          if (den < 0) begin
            den = -den; tn = -tn; sn = -sn;
          end
          if (!in_window(tn, den) || !in_window(sn, den)) continue;
          // clamp t to [0,1]
          if (tn < 0) begin
            num = 0; dn = 1;
          end else if (tn > den) begin
            num = 1; dn = 1;
          end else begin
            num = tn; dn = den;
          end
          // strict compare: the lower edge keeps a tie
          if (!have || num * best_den < best_num * dn) begin
            have = 1;
            res.edge_num = i[EdgeW-1:0];
            best_num = num;
            best_den = dn;
          end
        end
      end
      if (have) begin
        res.found = 1'b1;
        res.ent_x = entry_coord(x0, x1, best_num, best_den);
        res.ent_y = entry_coord(y0, y1, best_num, best_den);
      end else begin
        res.edge_num = '0;
      end
      pending_q.push_back(res);
    endfunction

    function void check_result(crossing_t got);
      crossing_t want;
      if (pending_q.size() == 0) begin
        $error("result item with no query outstanding");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.edge_num !== want.edge_num) begin
        $error("edge_index: expected %0d, actual %0d", want.edge_num, got.edge_num);
        errors++;
      end
      if (got.ent_x !== want.ent_x) begin
        $error("entry_x: expected %0d, actual %0d", want.ent_x, got.ent_x);
        errors++;
      end
      if (got.ent_y !== want.ent_y) begin
        $error("entry_y: expected %0d, actual %0d", want.ent_y, got.ent_y);
        errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 20_000_000;
  localparam int DrainCycles = 250;     // a write may still be in flight

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SDataW-1:0]   s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [MDataW-1:0]   m_tdata;
  logic                m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [PdataW-1:0]   pwdata = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  crossing_scoreboard  scb = new();
  int unsigned         cycle_cnt = 0;
  bit                  burst_mode = 0;  // stretches with no source gaps
  bit                  sink_burst = 0;  // stretches with no back-pressure

  segment_polygon_first_entry_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink: random stall per item, then accept and check.
  initial begin
    int unsigned stall;
    crossing_t   got;
    forever begin
      if ($urandom_range(0, 40) == 0) sink_burst = ~sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && rst_ni));
      got.found    = m_tuser;
      got.edge_num = m_tdata[3:0];
      got.ent_x    = m_tdata[35:4];
      got.ent_y    = m_tdata[67:36];
      scb.check_result(got);
    end
  end

  // One item on the input stream; noted once the handshake completes.
  task automatic send_item(op_e op, logic [SlotW-1:0] slot,
                           coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int unsigned gap;
    if ($urandom_range(0, 50) == 0) burst_mode = ~burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, y1, x1, y0, x0, slot};
    do @(posedge clk_i); while (!s_tready);
    scb.note_item(op, slot, x0, y0, x1, y1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (scb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of the vertex count: setup then access, block idle.
  task automatic set_vertex_count(int unsigned cnt);
    wait_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PaddrW'(CfgVertexCountIdx) << 2;
    pwdata  <= PdataW'(cnt);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scb.n_vertices = cnt & 5'h1f;
  endtask

  // Mostly small coordinates near the polygon so crossings are common,
  // with some full-range and corner values.
  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return coord_t'((int'($urandom_range(0, 40000)) - 20000) * 64);
    if (sel < 18) return coord_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  localparam coord_t U = 32'sd65536;   // 1.0 in Q16.16

  initial begin
    int unsigned items;
    int unsigned n;
    op_e         op;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every slot so no query can read an unwritten vertex.
    send_item(OP_WRITE, 4'd0, -10 * U, -10 * U, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(OP_WRITE, 4'd1, 10 * U, -10 * U, 0, 0);
    send_item(OP_WRITE, 4'd2, 10 * U, 10 * U, 0, 0);
    send_item(OP_WRITE, 4'd3, -10 * U, 10 * U, 0, 0);
    for (int s = 4; s < DefMaxVertices; s++)
      send_item(OP_WRITE, s[SlotW-1:0], pick_coord(), pick_coord(), 0, 0);
    send_item(OP_WRITE, 4'hf, 32'sh7fff_ffff, 32'sh8000_0000, -1, -1);

    // reset count of three: triangle of slots 0..2
    send_item(OP_QUERY, 4'hf, -20 * U, 0, 20 * U, 0);           // crosses
    send_item(OP_QUERY, 4'd0, 3 * U, 3 * U, 3 * U, 3 * U);      // degenerate
    send_item(OP_QUERY, 4'd0, 20 * U, 20 * U, 30 * U, 25 * U);  // miss

    set_vertex_count(4);
    send_item(OP_QUERY, 4'd0, -20 * U, -10 * U, 20 * U, -10 * U); // along edge
    send_item(OP_QUERY, 4'd0, -20 * U, -20 * U, 20 * U, 20 * U);  // via corner
    send_item(OP_QUERY, 4'd0, 0, 0, 20 * U, 5 * U);               // from inside
    send_item(OP_QUERY, 4'd0, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(OP_QUERY, 4'd0, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7fff_ffff);
    send_item(OP_QUERY, 4'd0, -10 * U, -10 * U, 5 * U, 0);      // starts on vertex

    set_vertex_count(2);                                         // too few
    send_item(OP_QUERY, 4'd0, -20 * U, 0, 20 * U, 0);
    set_vertex_count(31);                                        // clipped to 16
    send_item(OP_QUERY, 4'd0, -20 * U, 0, 20 * U, 0);
    send_item(OP_QUERY, 4'd0, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    set_vertex_count(16);
    send_item(OP_QUERY, 4'd0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 0);

    // Random phases over several vertex counts, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: n = 3;
        1: n = 16;
        default: n = $urandom_range(3, 16);
      endcase
      set_vertex_count(n);
      items = 200;
      for (int k = 0; k < items; k++) begin
        op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_QUERY;
        send_item(op, SlotW'($urandom_range(0, 15)), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord());
      end
    end

    wait_idle();
    if (scb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
